// ----- rtl/core/jiss_pkg.sv -----
// Shared types and constants for the JPEG image size scanner.
package jiss_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic        found;
		logic [31:0] image_width;
		logic [31:0] image_height;
	} out_beat_t;

	localparam logic [7:0]  MARK_PREFIX = 8'hFF;
	localparam logic [7:0]  SOF0        = 8'hC0;
	localparam logic [7:0]  SOF3        = 8'hC3;
	localparam logic [7:0]  SOF9        = 8'hC9;
	localparam logic [7:0]  SOF11       = 8'hCB;
	localparam logic [7:0]  APP1        = 8'hE1;
	localparam logic [15:0] TAG_EXIF    = 16'h8769;
	localparam logic [15:0] TAG_PIXX    = 16'hA002;
	localparam logic [15:0] TAG_PIXY    = 16'hA003;
	localparam logic [7:0]  CHAR_M      = 8'h4D;
	localparam logic [7:0]  CHAR_E      = 8'h45;
	localparam logic [7:0]  CHAR_X      = 8'h78;
	localparam logic [7:0]  CHAR_I      = 8'h69;
	localparam logic [7:0]  CHAR_F      = 8'h66;
	localparam logic [15:0] TYPE_SHORT  = 16'd3;
	localparam logic [15:0] TYPE_LONG   = 16'd4;

endpackage

// ----- rtl/core/jiss_ram.sv -----
// Generic single-port synchronous RAM with registered read.
module jiss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/core/jiss_walker.sv -----
// Marker and Exif IFD walker: sequencer that reads the byte buffer one byte at a time.
module jiss_walker #(
	parameter int AW = 12,
	parameter int NW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] count,
	output logic          busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          done,
	output logic          res_found,
	output logic [31:0]   res_w,
	output logic [31:0]   res_h
);
	// offsets held with headroom so that sums never wrap
	localparam int OW = 34;

	typedef enum logic [3:0] {
		S_IDLE, S_MHDR, S_MCHK, S_SOF, S_APP, S_EXHDR, S_IFD0CNT,
		S_IFD0ENT, S_SUBCNT, S_SUBENT, S_FETCH, S_DONE
	} state_t;

	state_t        state_q, ret_q;
	logic [OW-1:0] idx_q, base_q, ent_q, faddr_q;
	logic [NW-1:0] n_q;
	logic [15:0]   cnt_q, k_q;
	logic [3:0]    fi_q;      // bytes fetched into buffer
	logic [3:0]    flen_q;    // bytes to fetch
	logic          pend_q;    // read issued last cycle
	logic [7:0]    fb_q [12];
	logic          be_q, found_q;
	logic [31:0]   w_q, h_q;
	logic [31:0]   sub_off_q;

	logic [OW-1:0] n_ext;
	assign n_ext = OW'(n_q);

	function automatic logic [15:0] g16(input logic [7:0] a, input logic [7:0] b,
			input logic be);
		g16 = be ? {a, b} : {b, a};
	endfunction

	function automatic logic [31:0] g32(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic be);
		g32 = be ? {a, b, c, d} : {d, c, b, a};
	endfunction

	logic in_range;
	assign in_range = (faddr_q + OW'(fi_q)) < n_ext;

	assign busy    = (state_q != S_IDLE);
	assign rd_en   = (state_q == S_FETCH) && (fi_q < flen_q) && !pend_q;
	assign rd_addr = AW'(faddr_q + OW'(fi_q));
	assign done    = (state_q == S_DONE);
	assign res_found = found_q;
	assign res_w   = found_q ? w_q : 32'd0;
	assign res_h   = found_q ? h_q : 32'd0;

	logic [7:0]    mk;
	logic [OW-1:0] nxt, ifd, sub;
	logic [15:0]   tag, typ;
	always_comb begin
		mk  = fb_q[1];
		nxt = idx_q + OW'(g16(fb_q[2], fb_q[3], 1'b1)) + OW'(2);
		// byte order taken straight from the TIFF header bytes
		ifd = base_q + OW'(g32(fb_q[4], fb_q[5], fb_q[6], fb_q[7],
			fb_q[0] == jiss_pkg::CHAR_M));
		sub = base_q + OW'(sub_off_q);
		tag = g16(fb_q[0], fb_q[1], be_q);
		typ = g16(fb_q[2], fb_q[3], be_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			pend_q  <= 1'b0;
			fi_q    <= '0;
			flen_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q   <= count;
						idx_q <= OW'(2);
						state_q <= S_MHDR;
					end
				end
				S_MHDR: begin
					// need idx + 9 < n
					if (idx_q + OW'(9) >= n_ext) begin
						found_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						faddr_q <= idx_q; flen_q <= 4'd10; fi_q <= '0;
						ret_q <= S_MCHK; state_q <= S_FETCH;
					end
				end
				S_MCHK: begin
					if (fb_q[0] != jiss_pkg::MARK_PREFIX) begin
						found_q <= 1'b0; state_q <= S_DONE;
					end else if ((mk >= jiss_pkg::SOF0 && mk <= jiss_pkg::SOF3) ||
							(mk >= jiss_pkg::SOF9 && mk <= jiss_pkg::SOF11)) begin
						w_q <= {16'd0, fb_q[7], fb_q[8]};
						h_q <= {16'd0, fb_q[5], fb_q[6]};
						found_q <= 1'b1; state_q <= S_DONE;
					end else if (nxt + OW'(9) >= n_ext) begin
						state_q <= S_APP;
					end else begin
						idx_q <= nxt; state_q <= S_MHDR;
					end
				end
				S_APP: begin
					// Exif segment header needs bytes up to idx+9; fetch idx+10.. header
					if (mk == jiss_pkg::APP1 && idx_q + OW'(10) < n_ext &&
							fb_q[4] == jiss_pkg::CHAR_E && fb_q[5] == jiss_pkg::CHAR_X &&
							fb_q[6] == jiss_pkg::CHAR_I && fb_q[7] == jiss_pkg::CHAR_F &&
							fb_q[8] == 8'd0 && fb_q[9] == 8'd0 &&
							idx_q + OW'(18) <= n_ext) begin
						base_q <= idx_q + OW'(10);
						faddr_q <= idx_q + OW'(10); flen_q <= 4'd8; fi_q <= '0;
						ret_q <= S_EXHDR; state_q <= S_FETCH;
					end else begin
						found_q <= 1'b0; state_q <= S_DONE;
					end
				end
				S_EXHDR: begin
					be_q <= (fb_q[0] == jiss_pkg::CHAR_M);
					w_q <= '0; h_q <= '0;
					ent_q <= ifd;
					state_q <= S_IFD0CNT;
					flen_q <= '0;
				end
				S_IFD0CNT: begin
					// first entry: fetch count, second entry: have count
					if (flen_q == 4'd0) begin
						if (ent_q + OW'(2) > n_ext) begin
							found_q <= 1'b0; state_q <= S_DONE;
						end else begin
							faddr_q <= ent_q; flen_q <= 4'd2; fi_q <= '0;
							ret_q <= S_IFD0CNT; state_q <= S_FETCH;
						end
					end else begin
						cnt_q <= g16(fb_q[0], fb_q[1], be_q);
						k_q <= '0;
						ent_q <= ent_q + OW'(2);
						sub_off_q <= '0;
						flen_q <= '0;
						state_q <= S_IFD0ENT;
					end
				end
				S_IFD0ENT: begin
					if (flen_q == 4'd0) begin
						if (k_q == cnt_q || ent_q + OW'(12) > n_ext) begin
							found_q <= 1'b0; state_q <= S_DONE;
						end else begin
							faddr_q <= ent_q; flen_q <= 4'd12; fi_q <= '0;
							ret_q <= S_IFD0ENT; state_q <= S_FETCH;
						end
					end else begin
						flen_q <= '0;
						if (tag == jiss_pkg::TAG_EXIF) begin
							if (g32(fb_q[8], fb_q[9], fb_q[10], fb_q[11], be_q) == 32'd0) begin
								found_q <= 1'b0; state_q <= S_DONE;
							end else begin
								sub_off_q <= g32(fb_q[8], fb_q[9], fb_q[10], fb_q[11], be_q);
								state_q <= S_SUBCNT;
							end
						end else begin
							k_q <= k_q + 16'd1;
							ent_q <= ent_q + OW'(12);
						end
					end
				end
				S_SUBCNT: begin
					if (flen_q == 4'd0) begin
						if (sub + OW'(2) > n_ext) begin
							found_q <= 1'b0; state_q <= S_DONE;
						end else begin
							faddr_q <= sub; flen_q <= 4'd2; fi_q <= '0;
							ret_q <= S_SUBCNT; state_q <= S_FETCH;
						end
					end else begin
						cnt_q <= g16(fb_q[0], fb_q[1], be_q);
						k_q <= '0;
						ent_q <= sub + OW'(2);
						flen_q <= '0;
						state_q <= S_SUBENT;
					end
				end
				S_SUBENT: begin
					if (flen_q == 4'd0) begin
						if (k_q == cnt_q || ent_q + OW'(12) > n_ext) begin
							found_q <= (w_q != 32'd0) && (h_q != 32'd0);
							state_q <= S_DONE;
						end else begin
							faddr_q <= ent_q; flen_q <= 4'd12; fi_q <= '0;
							ret_q <= S_SUBENT; state_q <= S_FETCH;
						end
					end else begin
						flen_q <= '0;
						k_q <= k_q + 16'd1;
						ent_q <= ent_q + OW'(12);
						if (tag == jiss_pkg::TAG_PIXX || tag == jiss_pkg::TAG_PIXY) begin
							if (typ == jiss_pkg::TYPE_LONG) begin
								if (tag == jiss_pkg::TAG_PIXX)
									w_q <= g32(fb_q[8], fb_q[9], fb_q[10], fb_q[11], be_q);
								else
									h_q <= g32(fb_q[8], fb_q[9], fb_q[10], fb_q[11], be_q);
							end else if (typ == jiss_pkg::TYPE_SHORT) begin
								if (tag == jiss_pkg::TAG_PIXX)
									w_q <= {16'd0, g16(fb_q[8], fb_q[9], be_q)};
								else
									h_q <= {16'd0, g16(fb_q[8], fb_q[9], be_q)};
							end
						end
					end
				end
				S_FETCH: begin
					// one read in flight; out-of-range bytes read as zero
					if (pend_q) begin
						pend_q <= 1'b0;
						fb_q[fi_q] <= rd_data;
						fi_q <= fi_q + 4'd1;
						if (fi_q + 4'd1 == flen_q) state_q <= ret_q;
					end else if (!in_range) begin
						fb_q[fi_q] <= 8'd0;
						fi_q <= fi_q + 4'd1;
						if (fi_q + 4'd1 == flen_q) state_q <= ret_q;
					end else begin
						pend_q <= 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/jpeg_image_size_scanner_unit.sv -----
// JPEG image size scanner: loads a file one byte per beat into an on-chip buffer, then walks
// the marker segments (and an Exif IFD chain when needed) to report the image dimensions.
// After the last byte the walker reads the buffer through its single RAM port, fetching 10
// bytes per marker and 12 per IFD entry, and input is held off until the result beat is taken.
// Bytes past BUF_BYTES are dropped.
module jpeg_image_size_scanner_unit #(
	parameter int BUF_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jiss_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output jiss_pkg::out_beat_t out_data
);
	localparam int AW = $clog2(BUF_BYTES);
	localparam int NW = $clog2(BUF_BYTES + 1);

	logic [NW-1:0] cnt_q;
	logic          busy, done, rd_en, start_q, res_f;
	logic [AW-1:0] rd_addr, ram_addr;
	logic [7:0]    rd_data;
	logic [31:0]   res_w, res_h;
	logic          acc, we;

	assign in_ready = !busy && !start_q && !out_valid;
	assign acc      = in_valid && in_ready;
	assign we       = acc && (cnt_q < NW'(BUF_BYTES));
	assign ram_addr = rd_en ? rd_addr : AW'(cnt_q);

	jiss_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(in_data.data_byte), .rdata(rd_data)
	);

	logic [NW-1:0] fin_cnt;
	assign fin_cnt = we ? cnt_q + NW'(1) : cnt_q;
	logic [NW-1:0] n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			start_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (acc) begin
				if (in_data.last_byte) begin
					n_q <= fin_cnt;
					cnt_q <= '0;
					start_q <= 1'b1;
				end else begin
					cnt_q <= fin_cnt;
				end
			end
			if (done) begin
				out_valid <= 1'b1;
				out_data  <= '{found: res_f, image_width: res_w, image_height: res_h};
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	jiss_walker #(.AW(AW), .NW(NW)) u_walk (
		.clk(clk), .arst_n(arst_n), .start(start_q), .count(n_q), .busy(busy),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data), .done(done),
		.res_found(res_f), .res_w(res_w), .res_h(res_h)
	);
endmodule
